### hw/rtl/sorted_list_intersection_top_defines.svh
// Assertion macros shared by the sorted list intersection RTL.
`ifndef SORTED_LIST_INTERSECTION_TOP_DEFINES_SVH
`define SORTED_LIST_INTERSECTION_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Plain property check.
`define SLI_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Same-cycle implication.
`define SLI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define SLI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SLI_ASSERT(label, clk, rst_n, prop, msg)
`define SLI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SLI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### hw/rtl/slic_pkg.sv
// Types and constants of the sorted list intersection block.
package slic_pkg;

	localparam int VAL_W = 32;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_MERGE,
		ST_FLUSH
	} state_t;

	typedef enum logic {
		KIND_FIRST  = 1'b0,
		KIND_SECOND = 1'b1
	} kind_t;

	typedef struct packed {
		logic                    kind;
		logic signed [VAL_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] common_value;
		logic                    empty_res;
		logic                    last;
	} out_item_t;

	// Control for one row of sorting cells.
	typedef struct packed {
		logic                    ins;
		logic                    shift;
		logic                    clear;
		logic signed [VAL_W-1:0] value;
	} row_ctl_t;

endpackage

### hw/rtl/slic_chan_if.sv
// Valid/ready channel carrying one payload beat.
interface slic_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/slic_cell.sv
// One sorting cell: holds one list element, inserts in order, shifts toward the head.
module slic_cell #(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  logic                                 clk,
	input  slic_pkg::row_ctl_t                   ctl,
	input  logic [CW-1:0]                        cnt,
	input  logic signed [slic_pkg::VAL_W-1:0]    left_val,
	input  logic                                 left_gt,
	input  logic signed [slic_pkg::VAL_W-1:0]    right_val,
	output logic signed [slic_pkg::VAL_W-1:0]    val,
	output logic                                 gt
);

	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	logic signed [slic_pkg::VAL_W-1:0] val_q;
	logic                              take;

	// Occupied cells holding a larger value move right to make room.
	assign gt   = (IDX_C < cnt) && (val_q > ctl.value);
	assign take = gt || (cnt == IDX_C);
	assign val  = val_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && take) begin
			val_q <= left_gt ? left_val : ctl.value;
		end else if (ctl.shift) begin
			val_q <= right_val;
		end
	end

endmodule

### hw/rtl/slic_row.sv
// Row of sorting cells for one list, with its fill count.
module slic_row #(
	parameter int LIST_LEN = 16,
	parameter int CW       = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  slic_pkg::row_ctl_t                ctl,
	output logic signed [slic_pkg::VAL_W-1:0] head,
	output logic [CW-1:0]                     count
);

	logic signed [slic_pkg::VAL_W-1:0] vals [LIST_LEN];
	logic                              gts  [LIST_LEN];
	logic [CW-1:0]                     cnt_q;

	for (genvar i = 0; i < LIST_LEN; i++) begin : g_cell
		logic signed [slic_pkg::VAL_W-1:0] lv;
		logic                              lg;
		logic signed [slic_pkg::VAL_W-1:0] rv;

		if (i == 0) begin : g_first
			assign lv = vals[0];
			assign lg = 1'b0;
		end else begin : g_mid
			assign lv = vals[i-1];
			assign lg = gts[i-1];
		end
		if (i == LIST_LEN - 1) begin : g_end
			assign rv = vals[i];
		end else begin : g_inner
			assign rv = vals[i+1];
		end

		slic_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.cnt       (cnt_q),
			.left_val  (lv),
			.left_gt   (lg),
			.right_val (rv),
			.val       (vals[i]),
			.gt        (gts[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.clear) begin
			cnt_q <= '0;
		end else if (ctl.ins) begin
			cnt_q <= cnt_q + CW'(1);
		end else if (ctl.shift) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	assign head  = vals[0];
	assign count = cnt_q;

endmodule

### hw/rtl/sorted_list_intersection_top.sv
// Sorted list intersection: two rows of insertion-sort cells loaded one value per beat
// (LIST_LEN values per list, values for a full list are taken and dropped). Once both
// lists are full the rows shift their heads against each other, one compare per cycle,
// until a row runs dry; a flush state then loads the final beat. Each distinct common
// value leaves ascending, the final beat marked last, or one empty beat if none match.
// Input is not taken during that merge; output back-pressure stalls it.
`include "sorted_list_intersection_top_defines.svh"

module sorted_list_intersection_top #(
	parameter int LIST_LEN = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	slic_chan_if.sink   items,
	slic_chan_if.source results
);

	localparam int            CW   = $clog2(LIST_LEN + 1);
	localparam logic [CW-1:0] FULL = CW'(LIST_LEN);
	localparam logic [CW-1:0] NEAR = CW'(LIST_LEN - 1);

	slic_pkg::state_t                  state_q, state_nxt;
	slic_pkg::row_ctl_t                ctl_a, ctl_b;
	logic signed [slic_pkg::VAL_W-1:0] head_a, head_b;
	logic [CW-1:0]                     cnt_a, cnt_b;

	logic signed [slic_pkg::VAL_W-1:0] pend_q;
	logic                              have_q;
	slic_pkg::out_item_t               out_q;
	logic                              out_valid_q;

	logic accept, ins_a, ins_b, full_a, full_b, done_load;
	logic slot_free, is_eq, is_lt, is_gt, emit, push, step, merge_done;
	logic load_out, pend_set, pend_clr;
	slic_pkg::out_item_t out_nxt;

	assign full_a    = (cnt_a == FULL);
	assign full_b    = (cnt_b == FULL);
	assign accept    = items.valid && items.ready;
	assign ins_a     = accept && (items.data.kind == slic_pkg::KIND_FIRST) && !full_a;
	assign ins_b     = accept && (items.data.kind == slic_pkg::KIND_SECOND) && !full_b;
	assign done_load = (ins_a || ins_b)
		&& (full_a || (ins_a && cnt_a == NEAR))
		&& (full_b || (ins_b && cnt_b == NEAR));

	assign slot_free  = !out_valid_q || results.ready;
	assign merge_done = (cnt_a == '0) || (cnt_b == '0);
	assign is_eq      = (head_a == head_b);
	assign is_lt      = (head_a < head_b);
	assign is_gt      = (head_a > head_b);
	// Duplicates only ever repeat the most recent match.
	assign emit       = is_eq && (!have_q || pend_q != head_a);
	assign push       = emit && have_q;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			slic_pkg::ST_LOAD: begin
				if (done_load) state_nxt = slic_pkg::ST_MERGE;
			end
			slic_pkg::ST_MERGE: begin
				if (merge_done) state_nxt = slic_pkg::ST_FLUSH;
			end
			slic_pkg::ST_FLUSH: begin
				if (slot_free) state_nxt = slic_pkg::ST_LOAD;
			end
			default: state_nxt = slic_pkg::ST_LOAD;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		items.ready = 1'b0;
		step        = 1'b0;
		load_out    = 1'b0;
		pend_set    = 1'b0;
		pend_clr    = 1'b0;
		out_nxt     = '0;
		ctl_a       = '0;
		ctl_b       = '0;
		ctl_a.value = items.data.value;
		ctl_b.value = items.data.value;
		unique case (state_q)
			slic_pkg::ST_LOAD: begin
				items.ready = 1'b1;
				ctl_a.ins   = ins_a;
				ctl_b.ins   = ins_b;
			end
			slic_pkg::ST_MERGE: begin
				step        = !merge_done && (!push || slot_free);
				ctl_a.shift = step && (is_lt || is_eq);
				ctl_b.shift = step && (is_gt || is_eq);
				pend_set    = step && emit;
				load_out    = step && push;
				out_nxt.common_value = pend_q;
			end
			slic_pkg::ST_FLUSH: begin
				load_out    = slot_free;
				pend_clr    = slot_free;
				ctl_a.clear = slot_free;
				ctl_b.clear = slot_free;
				out_nxt.common_value = have_q ? pend_q : '0;
				out_nxt.empty_res    = !have_q;
				out_nxt.last         = 1'b1;
			end
			default: begin
				items.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= slic_pkg::ST_LOAD;
			have_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (pend_set) begin
				have_q <= 1'b1;
			end else if (pend_clr) begin
				have_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_set) pend_q <= head_a;
		if (load_out) out_q  <= out_nxt;
	end

	slic_row #(
		.LIST_LEN (LIST_LEN),
		.CW       (CW)
	) u_row_a (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_a),
		.head   (head_a),
		.count  (cnt_a)
	);

	slic_row #(
		.LIST_LEN (LIST_LEN),
		.CW       (CW)
	) u_row_b (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_b),
		.head   (head_b),
		.count  (cnt_b)
	);

	assign results.valid = out_valid_q;
	assign results.data  = out_q;

	`SLI_ASSERT_NXT(a_merge_full, clk, arst_n, (state_q == slic_pkg::ST_LOAD && done_load), (cnt_a == FULL && cnt_b == FULL), "merge entered with a list not full")
	`SLI_ASSERT(a_cnt_range, clk, arst_n, (cnt_a <= FULL && cnt_b <= FULL), "list count beyond capacity")
	`SLI_ASSERT_IMP(a_empty_form, clk, arst_n, (out_valid_q && out_q.empty_res), (out_q.last && out_q.common_value == '0), "empty beat malformed")
	`SLI_ASSERT_IMP(a_ascending, clk, arst_n, (state_q == slic_pkg::ST_MERGE && out_valid_q && !out_q.last && have_q), (pend_q > out_q.common_value), "results not ascending")

endmodule

### verif/tb_top.sv
// Testbench for sorted_list_intersection_top: random list pairs, predicted intersections.
`timescale 1ns / 1ps

module tb_top;

	localparam int LIST_LEN = 16;
	localparam int VAL_LO   = int'(32'h8000_0000);
	localparam int VAL_HI   = int'(32'h7fff_ffff);

	typedef int list_t[LIST_LEN];
	typedef enum {MIX_NEAR, MIX_SAME, MIX_EDGES, MIX_WIDE} mix_t;

	// Keeps both lists sorted as beats arrive and queues the common values each pair yields.
	class common_board;
		int                  rows[2][$];
		slic_pkg::out_item_t pending_common[$];
		int                  errors;

		function void note_value(slic_pkg::in_item_t beat);
			int                  k;
			int                  pos;
			int                  i;
			int                  j;
			bit                  have_prev;
			slic_pkg::out_item_t held;
			k = beat.kind;
			// a value for a list that is already full is dropped
			if (rows[k].size() >= LIST_LEN)
				return;
			pos = 0;
			while (pos < rows[k].size() && rows[k][pos] <= beat.value)
				pos++;
			rows[k].insert(pos, beat.value);
			if (rows[0].size() < LIST_LEN || rows[1].size() < LIST_LEN)
				return;
			i = 0;
			j = 0;
			have_prev = 1'b0;
			held = '0;
			while (i < LIST_LEN && j < LIST_LEN) begin
				if (rows[0][i] < rows[1][j]) begin
					i++;
				end else if (rows[1][j] < rows[0][i]) begin
					j++;
				end else begin
					if (!have_prev || held.common_value != rows[0][i]) begin
						if (have_prev)
							pending_common.push_back(held);
						held = '0;
						held.common_value = rows[0][i];
						have_prev = 1'b1;
					end
					i++;
					j++;
				end
			end
			if (have_prev) begin
				held.last = 1'b1;
				pending_common.push_back(held);
			end else begin
				held = '0;
				held.empty_res = 1'b1;
				held.last = 1'b1;
				pending_common.push_back(held);
			end
			rows[0].delete();
			rows[1].delete();
		endfunction

		function void check_common(slic_pkg::out_item_t got);
			slic_pkg::out_item_t want;
			if (pending_common.size() == 0) begin
				$error("result beat with nothing expected: common_value %0d", got.common_value);
				errors++;
				return;
			end
			want = pending_common.pop_front();
			if (got.common_value !== want.common_value) begin
				$error("common_value: expected %0d, got %0d", want.common_value,
					got.common_value);
				errors++;
			end
			if (got.empty_res !== want.empty_res) begin
				$error("empty_res: expected %0b, got %0b", want.empty_res, got.empty_res);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	slic_chan_if #(.T(slic_pkg::in_item_t))  items_ch ();
	slic_chan_if #(.T(slic_pkg::out_item_t)) results_ch ();

	sorted_list_intersection_top #(.LIST_LEN(LIST_LEN)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items_ch),
		.results(results_ch)
	);

	common_board board;
	int          burst_left;
	bit          sender_idles;
	int          extremes[10] = '{VAL_LO, VAL_LO + 1, -2, -1, 0, 1, 2, 999999999,
		VAL_HI - 1, VAL_HI};

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			items_ch.valid <= 1'b0;
		end
	endtask

	task automatic send_beat(input slic_pkg::kind_t k, input int v);
		if (burst_left == 0) begin
			if (sender_idles)
				idle_cycles($urandom_range(1, 6));
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		@(negedge clk);
		items_ch.valid      <= 1'b1;
		items_ch.data.kind  <= k;
		items_ch.data.value <= v;
		do @(posedge clk); while (!items_ch.ready);
		board.note_value(items_ch.data);
	endtask

	// Interleaves the two lists at random; extra beats for a full list go in while
	// the other one is still loading.
	task automatic send_set(input list_t a, input list_t b, input int drops);
		int              na;
		int              nb;
		slic_pkg::kind_t k;
		na = 0;
		nb = 0;
		while (na < LIST_LEN || nb < LIST_LEN) begin
			if (drops > 0 && ((na == LIST_LEN) != (nb == LIST_LEN)) &&
					$urandom_range(0, 3) == 0) begin
				k = (na == LIST_LEN) ? slic_pkg::KIND_FIRST : slic_pkg::KIND_SECOND;
				send_beat(k, int'($urandom));
				drops--;
			end else begin
				if (na == LIST_LEN)
					k = slic_pkg::KIND_SECOND;
				else if (nb == LIST_LEN)
					k = slic_pkg::KIND_FIRST;
				else
					k = ($urandom_range(0, 1) != 0) ? slic_pkg::KIND_SECOND
						: slic_pkg::KIND_FIRST;
				if (k == slic_pkg::KIND_FIRST) begin
					send_beat(k, a[na]);
					na++;
				end else begin
					send_beat(k, b[nb]);
					nb++;
				end
			end
		end
	endtask

	function automatic int draw_value(input mix_t mix, input int base, input int span);
		case (mix)
			MIX_WIDE:  return int'($urandom);
			MIX_EDGES: return extremes[$urandom_range(0, 9)];
			default:   return base + int'($urandom_range(0, span));
		endcase
	endfunction

	// Receiver: switches at random between four stall styles.
	initial begin
		int style;
		int tick;
		results_ch.ready = 1'b0;
		tick = 0;
		forever begin
			style = $urandom_range(0, 3);
			repeat ($urandom_range(20, 80)) begin
				@(negedge clk);
				tick++;
				case (style)
					0:       results_ch.ready <= 1'b1;
					1:       results_ch.ready <= ($urandom_range(0, 3) != 0);
					2:       results_ch.ready <= (tick % 5 == 0);
					default: results_ch.ready <= $urandom_range(0, 1);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && results_ch.valid && results_ch.ready)
			board.check_common(results_ch.data);
	end

	initial begin
		list_t a;
		list_t b;
		int    i;
		int    guard;
		int    loaded;
		int    pick;
		int    base;
		int    span;
		mix_t  mix;

		board            = new();
		arst_n           = 1'b0;
		items_ch.valid   = 1'b0;
		items_ch.data    = '0;
		burst_left       = 0;
		sender_idles     = 1'b1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// extremes, duplicates, the old sentinel value, unsorted arrival, dropped beats
		a = '{VAL_HI, 999999999, 5, 5, 5, 0, -1, VAL_LO, 3, 100, -100, 42, 7, VAL_LO + 1,
			1, 2};
		b = '{VAL_LO, 5, 5, 999999999, -1, 0, VAL_HI, 8, 9, 10, 11, 12, -7, 42, 42, 2};
		send_set(a, b, 3);
		// identical lists: every value common, smallest one the old sentinel
		for (i = 0; i < LIST_LEN; i++)
			a[i] = 999999999 + (LIST_LEN - 1 - i);
		send_set(a, a, 0);
		// nothing in common
		for (i = 0; i < LIST_LEN; i++) begin
			a[i] = -5;
			b[i] = i * 3 + 1;
		end
		send_set(a, b, 2);

		// the three directed pairs above count toward the total
		loaded = 6 * LIST_LEN;
		while (loaded < 300) begin
			pick = $urandom_range(0, 19);
			if (pick < 10)
				mix = MIX_NEAR;
			else if (pick < 14)
				mix = MIX_SAME;
			else if (pick < 17)
				mix = MIX_EDGES;
			else
				mix = MIX_WIDE;
			base = ($urandom_range(0, 3) == 0) ? VAL_HI - 20 : int'($urandom);
			span = $urandom_range(2, 40);
			sender_idles = ($urandom_range(0, 3) != 0);
			for (i = 0; i < LIST_LEN; i++) begin
				a[i] = draw_value((mix == MIX_SAME) ? MIX_NEAR : mix, base, span);
				b[i] = draw_value((mix == MIX_SAME) ? MIX_NEAR : mix, base, span);
			end
			if (mix == MIX_SAME) begin
				b = a;
				repeat ($urandom_range(0, 3))
					b[$urandom_range(0, LIST_LEN - 1)] = draw_value(MIX_NEAR, base, span);
			end
			send_set(a, b, ($urandom_range(0, 1) != 0) ? $urandom_range(1, 3) : 0);
			loaded += 2 * LIST_LEN;
		end
		idle_cycles(1);

		guard = 0;
		while (board.pending_common.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (2 * LIST_LEN + 20) @(posedge clk);
		if (board.pending_common.size() != 0) begin
			$error("%0d expected result beats never arrived", board.pending_common.size());
			board.errors++;
		end

		if (board.errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/slic_pkg.sv
hw/rtl/slic_chan_if.sv
hw/rtl/slic_cell.sv
hw/rtl/slic_row.sv
hw/rtl/sorted_list_intersection_top.sv
verif/tb_top.sv
